[hw/rtl/sli_pkg.sv]
// Package for the sorted list block: capacity, operation and status codes,
// beat types for both channels, and the link type between list cells.
// Depends on nothing; every other file refers to it by scoped names.
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_op               op;
        logic signed [7:0] value;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [4:0]        entry_count;
        logic              list_empty;
        logic signed [7:0] smallest_value;
    } t_out_item;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic signed [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic              valid;
        logic              ge;
        logic signed [7:0] value;
    } t_link;

endpackage

[hw/rtl/sli_cell.sv]
// One slot of the sorted list: holds a value and its valid bit, compares
// against the command value and shifts toward either neighbor.
// Depends on sli_pkg.
module sli_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sli_pkg::t_cmd  i_cmd,
    input  sli_pkg::t_link i_prev,
    input  sli_pkg::t_link i_next,
    output sli_pkg::t_link o_link,
    output logic          o_hit
);

    logic              r_valid;
    logic signed [7:0] r_value;
    logic              n_valid;
    logic signed [7:0] n_value;
    logic              ge;

    assign ge = !r_valid || (r_value >= i_cmd.value);

    assign o_link.valid = r_valid;
    assign o_link.ge    = ge;
    assign o_link.value = r_value;

    // The first valid slot whose value is at least the key is the only
    // candidate for a delete hit, since the list is sorted.
    assign o_hit = r_valid && (r_value == i_cmd.value) && !i_prev.ge;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_cmd.ins) begin
            n_valid = r_valid || i_prev.valid;
            if (i_prev.ge) begin
                n_value = i_prev.value;
            end else if (ge) begin
                n_value = i_cmd.value;
            end
        end else if (i_cmd.del && r_valid && ge) begin
            n_valid = i_next.valid;
            n_value = i_next.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

[hw/rtl/sorted_list_insert_delete_top.sv]
// Top level of the sorted list: a row of sli_cell slots, the entry counter
// and the registered status of each operation. Depends on sli_pkg, sli_cell.
//
//   channel   handshake           payload
//   command   i_start / o_busy    i_item   (sli_pkg::t_in_item)
//   result    o_done              o_result (sli_pkg::t_out_item)
//
// Every slot compares and shifts in the same cycle, so o_busy stays low
// and a new command beat may come every cycle; its result beat appears
// on o_done in the cycle after the command is taken.
// Synchronous reset empties the list at once and drops any pending result.
// The receiver cannot stall; each result beat is shown for one cycle only.
module sorted_list_insert_delete_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  sli_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_done,
    output sli_pkg::t_out_item o_result
);

    localparam int N = sli_pkg::CAPACITY;

    sli_pkg::t_link               links [N];
    logic           [N-1:0]       hits;
    sli_pkg::t_cmd                cmd;
    sli_pkg::t_status             r_status;
    sli_pkg::t_status             n_status;
    logic                         r_done;
    logic [sli_pkg::CNT_W-1:0]    r_count;
    logic [sli_pkg::CNT_W-1:0]    n_count;
    logic                         accept;
    logic                         full;
    logic                         found;
    logic [31:0]                  count_ext;

    assign accept = i_start && !o_busy;
    assign full   = links[N-1].valid;
    assign found  = |hits;

    assign cmd.value = i_item.value;
    assign cmd.ins   = accept && (i_item.op == sli_pkg::OP_INSERT) && !full;
    assign cmd.del   = accept && (i_item.op == sli_pkg::OP_DELETE) && found;

    for (genvar g = 0; g < N; g++) begin : g_cell
        sli_pkg::t_link prev_link;
        sli_pkg::t_link next_link;
        if (g == 0) begin : g_head
            assign prev_link = '{valid: 1'b1, ge: 1'b0, value: 8'sd0};
        end else begin : g_mid
            assign prev_link = links[g-1];
        end
        if (g == N - 1) begin : g_tail
            assign next_link = '{valid: 1'b0, ge: 1'b1, value: 8'sd0};
        end else begin : g_body
            assign next_link = links[g+1];
        end
        sli_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_prev  (prev_link),
            .i_next  (next_link),
            .o_link  (links[g]),
            .o_hit   (hits[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        if (accept) begin
            case (i_item.op)
                sli_pkg::OP_INSERT: begin
                    if (full) begin
                        n_status = sli_pkg::ST_FULL;
                    end else begin
                        n_status = sli_pkg::ST_INSERTED;
                        n_count  = r_count + 1'b1;
                    end
                end
                sli_pkg::OP_DELETE: begin
                    if (found) begin
                        n_status = sli_pkg::ST_DELETED;
                        n_count  = r_count - 1'b1;
                    end else begin
                        n_status = sli_pkg::ST_NOT_FOUND;
                    end
                end
                default: begin
                    n_status = sli_pkg::ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    assign count_ext = 32'(r_count);

    assign o_busy                  = 1'b0;
    assign o_done                  = r_done;
    assign o_result.status         = r_status;
    assign o_result.entry_count    = count_ext[4:0];
    assign o_result.list_empty     = !links[0].valid;
    assign o_result.smallest_value = links[0].valid ? links[0].value : 8'sd0;

endmodule

[hw/rtl/sli_chk.sv]
// Port-level checker for the sorted list top level, attached by bind.
// Depends on sli_pkg and sorted_list_insert_delete_top.
module sli_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_done,
    input sli_pkg::t_out_item o_result
);

    a_done_follows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_done)
        else $error("command beat without a result beat");

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy))
        else $error("result beat without a command beat");

    a_empty_smallest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.list_empty) |-> (o_result.smallest_value == 8'sd0))
        else $error("empty list reports a nonzero smallest entry");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == sli_pkg::ST_FULL)) |->
        (o_result.entry_count == 5'(sli_pkg::CAPACITY)))
        else $error("rejected insert while list not full");

    a_insert_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == sli_pkg::ST_INSERTED)) |-> !o_result.list_empty)
        else $error("list empty after a successful insert");

endmodule

bind sorted_list_insert_delete_top sli_chk u_sli_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);
